/* design/assert_macros.svh */
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition on one edge implies a consequence on the following edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/rgbch_pkg.sv */
// package: widths, latencies and the arctangent constants of the rgb angle unit
`timescale 1ns / 1ps

package rgbch_pkg;

    localparam int NUM_ITER    = 40;
    localparam int IN_SHIFT    = 23;
    localparam int FRAC        = 60;
    localparam int OUT_SHIFT   = 46;
    localparam int XY_W        = 36;
    localparam int Z_W         = 64;
    localparam int ANG_W       = 17;
    localparam int C_W         = 15;
    localparam int PIX_W       = 8;
    localparam int ROOT_W      = 32;
    localparam int REM_W       = 66;
    localparam int SQRT_STAGES = ROOT_W;
    localparam int CORDIC_LAT  = NUM_ITER + 3;
    localparam int PIPE_LAT    = 1 + SQRT_STAGES + CORDIC_LAT;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 64;

    localparam logic [C_W-1:0]          C_MAX     = 15'd25736;
    localparam logic signed [ANG_W-1:0] HUE_MAX   = 17'sd51472;
    localparam logic [Z_W-1:0]          ROUND_HALF = 64'd1 << (OUT_SHIFT - 1);

    // shift-and-subtract quotient, used only for constants at elaboration
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(1/n) with FRAC fraction bits, alternating series
    function automatic logic signed [Z_W-1:0] atan_inv(input logic [63:0] n);
        logic [63:0] term;
        logic [63:0] n2;
        logic [63:0] k;
        logic [63:0] part;
        logic signed [63:0] sum;
        term = udiv64(64'd1 << FRAC, n);
        n2   = n * n;
        sum  = '0;
        k    = '0;
        while (term != '0) begin
            part = udiv64(term, (k << 1) + 64'd1);
            if (k[0]) sum = sum - $signed(part);
            else      sum = sum + $signed(part);
            term = udiv64(term, n2);
            k    = k + 64'd1;
        end
        return sum;
    endfunction

    // atan(2^-i) with FRAC fraction bits, for i >= 1
    function automatic logic signed [Z_W-1:0] atan_pow2(input int i);
        logic [63:0] term;
        logic [63:0] k;
        logic [63:0] part;
        logic signed [63:0] sum;
        term = 64'd1 << (FRAC - i);
        sum  = '0;
        k    = '0;
        while (term != '0) begin
            part = udiv64(term, (k << 1) + 64'd1);
            if (k[0]) sum = sum - $signed(part);
            else      sum = sum + $signed(part);
            if (2 * i < 64) term = term >> (2 * i);
            else            term = '0;
            k = k + 64'd1;
        end
        return sum;
    endfunction

    // micro-rotation angle of iteration i; the first one is pi/4 by machin's formula
    function automatic logic signed [Z_W-1:0] atan_entry(input int i);
        logic signed [Z_W-1:0] val;
        if (i == 0) val = (atan_inv(64'd5) <<< 2) - atan_inv(64'd239);
        else        val = atan_pow2(i);
        return val;
    endfunction

    localparam logic signed [Z_W-1:0] QUARTER_PI = atan_entry(0);
    localparam logic signed [Z_W-1:0] HALF_PI    = {QUARTER_PI[Z_W-2:0], 1'b0};
    localparam logic signed [Z_W-1:0] FULL_PI    = {QUARTER_PI[Z_W-3:0], 2'b00};

endpackage

/* design/rgbch_atan2.sv */
// pipelined vectoring cordic: atan2 of one operand pair, one iteration per stage
`timescale 1ns / 1ps

module rgbch_atan2 import rgbch_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [XY_W-1:0]  i_x,
    input  logic signed [XY_W-1:0]  i_y,
    output logic signed [ANG_W-1:0] o_angle
);

    logic signed [XY_W-1:0] r_x    [0:NUM_ITER-1];
    logic signed [XY_W-1:0] r_y    [0:NUM_ITER-1];
    logic signed [Z_W-1:0]  r_z    [0:NUM_ITER];
    logic                   r_hold [0:NUM_ITER-1];

    logic signed [XY_W-1:0] n_x;
    logic signed [XY_W-1:0] n_y;
    logic signed [Z_W-1:0]  n_z;
    logic                   n_hold;

    logic [Z_W-1:0]          r_mag;
    logic                    r_neg;
    logic [Z_W-1:0]          rnd_sum;
    logic [ANG_W-1:0]        q_mag;
    logic signed [ANG_W-1:0] r_q;

    // fold the left half plane into the right one; zero and +pi cases bypass the iterations
    always_comb begin
        n_x    = i_x;
        n_y    = i_y;
        n_z    = '0;
        n_hold = 1'b0;
        if (i_y == '0 && i_x == '0) begin
            n_hold = 1'b1;
        end else if (i_y == '0 && i_x[XY_W-1]) begin
            n_hold = 1'b1;
            n_z    = FULL_PI;
        end else if (i_x[XY_W-1]) begin
            if (!i_y[XY_W-1]) begin
                n_x = i_y;
                n_y = -i_x;
                n_z = HALF_PI;
            end else begin
                n_x = -i_y;
                n_y = i_x;
                n_z = -HALF_PI;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= n_x;
            r_y[0]    <= n_y;
            r_z[0]    <= n_z;
            r_hold[0] <= n_hold;
        end
    end

    for (genvar k = 0; k < NUM_ITER; k++) begin : g_iter
        localparam logic signed [Z_W-1:0] ATAN_K = atan_entry(k);
        logic up;

        assign up = (r_y[k] > 0);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_hold[k])  r_z[k+1] <= r_z[k];
                else if (up)    r_z[k+1] <= r_z[k] + ATAN_K;
                else            r_z[k+1] <= r_z[k] - ATAN_K;
            end
        end

        // the last iteration only moves the angle
        if (k < NUM_ITER - 1) begin : g_xy
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_hold[k+1] <= r_hold[k];
                    if (r_hold[k]) begin
                        r_x[k+1] <= r_x[k];
                        r_y[k+1] <= r_y[k];
                    end else if (up) begin
                        r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                        r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    end else begin
                        r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                        r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    end
                end
            end
        end
    end

    // round to nearest, ties away from zero, on the magnitude
    assign rnd_sum = r_mag + ROUND_HALF;
    assign q_mag   = rnd_sum[OUT_SHIFT+ANG_W-1:OUT_SHIFT];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg <= r_z[NUM_ITER][Z_W-1];
            r_mag <= r_z[NUM_ITER][Z_W-1] ? Z_W'(-r_z[NUM_ITER]) : Z_W'(r_z[NUM_ITER]);
            r_q   <= r_neg ? -$signed(q_mag) : $signed(q_mag);
        end
    end

    assign o_angle = r_q;

endmodule

/* design/rgb_to_c1c2c3_and_hue_unit.sv */
// top level: c1c2c3 colour invariants and hue angle of a pixel stream
//
//  channel   direction  tdata fields (lsb first)
//  s_axis    in         red[7:0] green[15:8] blue[23:16]
//  m_axis    out        c1[14:0] c2[29:15] c3[44:30] hue[61:45] zero[63:62]
//
// one item per clock sustained while the output is not stalled; 77 register stages: one set-up
// stage, 32 square-root stages for sqrt3*|g-b|, one fold stage, 40 cordic iteration stages,
// two rounding stages and the output register.
// synchronous active-low reset clears the pipeline valid bits and the output and skid valid flags.
// a stalled output parks one item in the skid slot, then the whole pipeline holds.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rgb_to_c1c2c3_and_hue_unit import rgbch_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // red, green, blue
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata   // c1, c2, c3, hue, zero pad
);

    typedef struct packed {
        logic [PIX_W-1:0] c1_num;
        logic [PIX_W-1:0] c1_den;
        logic [PIX_W-1:0] c2_num;
        logic [PIX_W-1:0] c2_den;
        logic [PIX_W-1:0] c3_num;
        logic [PIX_W-1:0] c3_den;
        logic signed [9:0] hue_x;
        logic              hue_neg;
    } t_side;

    logic en;
    logic out_free;

    logic r_vld [0:PIPE_LAT-1];

    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic signed [8:0] diff_gb;
    logic [PIX_W-1:0]  abs_gb;
    logic [15:0]       sq_gb;
    logic [17:0]       n_sq;
    t_side             n_side;

    t_side              r_side [0:SQRT_STAGES];
    logic [REM_W-1:0]   r_rem  [0:SQRT_STAGES-1];
    logic [ROOT_W-1:0]  r_root [1:SQRT_STAGES];

    logic signed [XY_W-1:0] c1_x, c1_y, c2_x, c2_y, c3_x, c3_y, hue_x, hue_y;
    logic signed [ANG_W-1:0] c1_ang, c2_ang, c3_ang, hue_ang;

    logic [C_W-1:0]          n_out_c1, n_out_c2, n_out_c3;
    logic signed [ANG_W-1:0] n_out_hue;

    logic                    r_out_valid;
    logic [C_W-1:0]          r_out_c1, r_out_c2, r_out_c3;
    logic signed [ANG_W-1:0] r_out_hue;
    logic                    r_skid_valid;
    logic [C_W-1:0]          r_skid_c1, r_skid_c2, r_skid_c3;
    logic signed [ANG_W-1:0] r_skid_hue;

    function automatic logic [C_W-1:0] clamp_c(input logic signed [ANG_W-1:0] v);
        logic [C_W-1:0] res;
        if (v[ANG_W-1])                              res = '0;
        else if (v > $signed({2'b00, C_MAX}))        res = C_MAX;
        else                                         res = v[C_W-1:0];
        return res;
    endfunction

    function automatic logic signed [ANG_W-1:0] clamp_hue(input logic signed [ANG_W-1:0] v);
        logic signed [ANG_W-1:0] res;
        if (v > HUE_MAX)       res = HUE_MAX;
        else if (v < -HUE_MAX) res = -HUE_MAX;
        else                   res = v;
        return res;
    endfunction

    assign en              = !r_skid_valid;
    assign o_s_axis_tready = en;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    // set-up stage: denominators, hue x and 3*(g-b)^2
    assign red     = i_s_axis_tdata[7:0];
    assign green   = i_s_axis_tdata[15:8];
    assign blue    = i_s_axis_tdata[23:16];
    assign diff_gb = $signed({1'b0, green}) - $signed({1'b0, blue});
    assign abs_gb  = diff_gb[8] ? PIX_W'(-diff_gb) : diff_gb[PIX_W-1:0];
    assign sq_gb   = abs_gb * abs_gb;
    assign n_sq    = {2'b00, sq_gb} + {1'b0, sq_gb, 1'b0};

    always_comb begin
        n_side.c1_num  = red;
        n_side.c1_den  = (green > blue) ? green : blue;
        n_side.c2_num  = green;
        n_side.c2_den  = (red > blue) ? red : blue;
        n_side.c3_num  = blue;
        n_side.c3_den  = (red > green) ? red : green;
        n_side.hue_x   = $signed({1'b0, red, 1'b0}) - $signed({2'b00, green})
                         - $signed({2'b00, blue});
        n_side.hue_neg = diff_gb[8];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= n_side;
            r_rem[0]  <= REM_W'({n_sq, {OUT_SHIFT{1'b0}}});
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < PIPE_LAT; v++) r_vld[v] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_s_axis_tvalid;
            for (int v = 1; v < PIPE_LAT; v++) r_vld[v] <= r_vld[v-1];
        end
    end

    // restoring square root, one root bit per stage, msb first
    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
        localparam int J = ROOT_W - 1 - k;
        logic [ROOT_W-1:0] root_in;
        logic [REM_W-1:0]  trial;
        logic              take;

        if (k == 0) begin : g_first
            assign root_in = '0;
        end else begin : g_rest
            assign root_in = r_root[k];
        end

        assign trial = (REM_W'(root_in) << (J + 1)) + (REM_W'(1) << (2 * J));
        assign take  = (r_rem[k] >= trial);

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_side[k+1] <= r_side[k];
                r_root[k+1] <= take ? (root_in | (ROOT_W'(1) << J)) : root_in;
            end
        end

        if (k < SQRT_STAGES - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (en) r_rem[k+1] <= take ? (r_rem[k] - trial) : r_rem[k];
            end
        end
    end

    assign c1_x  = XY_W'(r_side[SQRT_STAGES].c1_den) <<< IN_SHIFT;
    assign c1_y  = XY_W'(r_side[SQRT_STAGES].c1_num) <<< IN_SHIFT;
    assign c2_x  = XY_W'(r_side[SQRT_STAGES].c2_den) <<< IN_SHIFT;
    assign c2_y  = XY_W'(r_side[SQRT_STAGES].c2_num) <<< IN_SHIFT;
    assign c3_x  = XY_W'(r_side[SQRT_STAGES].c3_den) <<< IN_SHIFT;
    assign c3_y  = XY_W'(r_side[SQRT_STAGES].c3_num) <<< IN_SHIFT;
    assign hue_x = XY_W'(r_side[SQRT_STAGES].hue_x) <<< IN_SHIFT;
    assign hue_y = r_side[SQRT_STAGES].hue_neg ? -$signed(XY_W'(r_root[SQRT_STAGES]))
                                               : $signed(XY_W'(r_root[SQRT_STAGES]));

    rgbch_atan2 u_c1 (.i_clk(i_clk), .i_en(en), .i_x(c1_x), .i_y(c1_y), .o_angle(c1_ang));
    rgbch_atan2 u_c2 (.i_clk(i_clk), .i_en(en), .i_x(c2_x), .i_y(c2_y), .o_angle(c2_ang));
    rgbch_atan2 u_c3 (.i_clk(i_clk), .i_en(en), .i_x(c3_x), .i_y(c3_y), .o_angle(c3_ang));
    rgbch_atan2 u_hue (.i_clk(i_clk), .i_en(en), .i_x(hue_x), .i_y(hue_y), .o_angle(hue_ang));

    assign n_out_c1  = clamp_c(c1_ang);
    assign n_out_c2  = clamp_c(c2_ang);
    assign n_out_c3  = clamp_c(c3_ang);
    assign n_out_hue = clamp_hue(hue_ang);

    // output register with one skid slot behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_free) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (r_vld[PIPE_LAT-1]) begin
            if (out_free) r_out_valid  <= 1'b1;
            else          r_skid_valid <= 1'b1;
        end else if (out_free) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_free) begin
                r_out_c1  <= r_skid_c1;
                r_out_c2  <= r_skid_c2;
                r_out_c3  <= r_skid_c3;
                r_out_hue <= r_skid_hue;
            end
        end else if (r_vld[PIPE_LAT-1]) begin
            if (out_free) begin
                r_out_c1  <= n_out_c1;
                r_out_c2  <= n_out_c2;
                r_out_c3  <= n_out_c3;
                r_out_hue <= n_out_hue;
            end else begin
                r_skid_c1  <= n_out_c1;
                r_skid_c2  <= n_out_c2;
                r_skid_c3  <= n_out_c3;
                r_skid_hue <= n_out_hue;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_hue, r_out_c3, r_out_c2, r_out_c1};

    `ASSERT_CLK(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid |-> r_out_valid, "skid item without output item")
    `ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, r_vld[0], "accepted item missing from first stage")
    `ASSERT_NEXT(a_stall_to_skid, i_clk, i_rst_n, !r_skid_valid && r_out_valid && !i_m_axis_tready && r_vld[PIPE_LAT-1], r_skid_valid, "item leaving pipeline was dropped")
    `ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, r_skid_valid && i_m_axis_tready, !r_skid_valid, "skid slot did not drain")
    `ASSERT_CLK(a_c_range, i_clk, i_rst_n, r_out_valid |-> (r_out_c1 <= C_MAX && r_out_c2 <= C_MAX && r_out_c3 <= C_MAX), "invariant angle out of range")

endmodule

/* bench/tb_rgb_to_c1c2c3_and_hue_unit.sv */
// testbench for the rgb to c1c2c3 and hue angle unit: bit-exact predictor and stream checks
`timescale 1ns / 1ps

module tb_rgb_to_c1c2c3_and_hue_unit;
    import rgbch_pkg::*;

    localparam int     ROT_STEPS   = 40;
    localparam int     ACC_FRAC    = 60;
    localparam int     OPND_SH     = 23;
    localparam int     OUT_SH      = 46;
    localparam longint C_CEIL      = 25736;
    localparam longint HUE_CEIL    = 51472;
    localparam int     PIPE_CYCLES = 76;
    localparam int     PAD_LSB     = 3 * C_W + ANG_W;
    localparam longint unsigned ROUND_ADD = 64'd1 << (OUT_SH - 1);

    typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_EVERY_4TH, RDY_MOSTLY} t_ready_mode;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } t_rgb;

    typedef struct {
        logic [PIX_W-1:0]        red;
        logic [PIX_W-1:0]        green;
        logic [PIX_W-1:0]        blue;
        logic [C_W-1:0]          c1;
        logic [C_W-1:0]          c2;
        logic [C_W-1:0]          c3;
        logic signed [ANG_W-1:0] hue;
    } t_pixel_angles;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;   // red, green, blue
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;   // c1, c2, c3, hue, zero pad

    longint        atan_steps [ROT_STEPS];
    longint        pi_half;
    longint        pi_full;
    t_pixel_angles angles_due [$];
    t_pixel_angles want;
    int            mismatches = 0;

    // sender burst state
    bit            gaps_on    = 1'b1;
    int            burst_left = 0;

    // receiver stall state; a hold-off is requested by bumping hold_seq
    int            hold_seq   = 0;
    int            hold_seen  = 0;
    int            hold_len   = 0;
    int            hold_left  = 0;
    int            mode_left  = 0;
    int            tick       = 0;
    t_ready_mode   rdy_mode   = RDY_ALWAYS;

    rgb_to_c1c2c3_and_hue_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // atan(1/n) with 60 fraction bits
    function automatic longint atan_recip(longint unsigned n);
        longint unsigned term;
        longint unsigned n2;
        longint unsigned k;
        longint unsigned part;
        longint          acc;
        term = (64'd1 << ACC_FRAC) / n;
        n2   = n * n;
        acc  = 0;
        k    = 0;
        while (term != 0) begin
            part = term / (2 * k + 1);
            if (k[0]) acc -= $signed(part);
            else acc += $signed(part);
            term = term / n2;
            k++;
        end
        return acc;
    endfunction

    // atan(2^-i) with 60 fraction bits, i >= 1
    function automatic longint atan_shifted(int i);
        longint unsigned term;
        longint unsigned k;
        longint unsigned part;
        longint          acc;
        term = 64'd1 << (ACC_FRAC - i);
        acc  = 0;
        k    = 0;
        while (term != 0) begin
            part = term / (2 * k + 1);
            if (k[0]) acc -= $signed(part);
            else acc += $signed(part);
            term = (2 * i < 64) ? (term >> (2 * i)) : 64'd0;
            k++;
        end
        return acc;
    endfunction

    function automatic longint unsigned isqrt_u64(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n    = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // vectoring cordic, operands carry 23 fraction bits, result in radians * 16384
    function automatic longint cordic_atan2(longint y, longint x);
        longint z;
        longint dx;
        longint dy;
        longint t;
        if (y == 0 && x == 0) return 0;
        z = 0;
        if (y == 0 && x < 0) begin
            z = pi_full;
        end else begin
            // fold the left half plane over by a quarter turn
            if (x < 0) begin
                t = x;
                if (y >= 0) begin
                    x = y;
                    y = -t;
                    z = pi_half;
                end else begin
                    x = -y;
                    y = t;
                    z = -pi_half;
                end
            end
            for (int i = 0; i < ROT_STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y > 0) begin
                    x += dx;
                    y -= dy;
                    z += atan_steps[i];
                end else begin
                    x -= dx;
                    y += dy;
                    z -= atan_steps[i];
                end
            end
        end
        // round half away from zero
        if (z >= 0) return $signed(($unsigned(z) + ROUND_ADD) >> OUT_SH);
        return -$signed(($unsigned(-z) + ROUND_ADD) >> OUT_SH);
    endfunction

    function automatic logic [C_W-1:0] chroma_angle(longint num, longint a, longint b);
        longint v;
        v = cordic_atan2(num <<< OPND_SH, ((a > b) ? a : b) <<< OPND_SH);
        if (v < 0) v = 0;
        if (v > C_CEIL) v = C_CEIL;
        return v[C_W-1:0];
    endfunction

    function automatic t_pixel_angles predict_angles(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                                     logic [PIX_W-1:0] b);
        t_pixel_angles   res;
        longint          d;
        longint          e;
        longint          y;
        longint          h;
        longint unsigned ad;
        longint unsigned sq;
        res.red   = r;
        res.green = g;
        res.blue  = b;
        res.c1    = chroma_angle(r, g, b);
        res.c2    = chroma_angle(g, r, b);
        res.c3    = chroma_angle(b, r, g);
        d  = longint'(g) - longint'(b);
        e  = 2 * longint'(r) - longint'(g) - longint'(b);
        ad = (d < 0) ? -d : d;
        // sqrt3 * |g-b| truncated to 23 fraction bits
        sq = 3 * ad * ad;
        y  = $signed(isqrt_u64(sq << (2 * OPND_SH)));
        if (d < 0) y = -y;
        h = cordic_atan2(y, e <<< OPND_SH);
        if (h > HUE_CEIL) h = HUE_CEIL;
        if (h < -HUE_CEIL) h = -HUE_CEIL;
        res.hue = h[ANG_W-1:0];
        return res;
    endfunction

    function automatic t_rgb random_rgb();
        t_rgb             px;
        logic [PIX_W-1:0] corners [4];
        corners = '{8'd0, 8'd1, 8'd254, 8'd255};
        px = t_rgb'(24'($urandom));
        case ($urandom_range(0, 9))
            0, 1, 2, 3: ;
            // green equal to blue: hue is zero or a straight angle
            4: px.blue = px.green;
            // 2r = g + b puts the hue operand on the vertical axis
            5: begin
                px.blue[0] = px.green[0];
                px.red     = 8'(({1'b0, px.green} + px.blue) >> 1);
            end
            6: px = t_rgb'(px & 24'h030303);
            7: begin
                if ($urandom_range(0, 1)) px.red = corners[$urandom_range(0, 3)];
                if ($urandom_range(0, 1)) px.green = corners[$urandom_range(0, 3)];
                if ($urandom_range(0, 1)) px.blue = corners[$urandom_range(0, 3)];
            end
            // hue just either side of the straight angle
            8: begin
                px.red  = 8'($urandom_range(0, 3));
                px.blue = px.green + ($urandom_range(0, 1) ? 8'd1 : 8'hFF);
            end
            default: px = t_rgb'(px & (24'hFF << (8 * $urandom_range(0, 2))));
        endcase
        return px;
    endfunction

    task automatic push_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g, logic [PIX_W-1:0] b);
        if (gaps_on && burst_left == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 48);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {b, g, r};
        do @(posedge i_clk); while (!o_s_axis_tready);
        angles_due.insert(angles_due.size(), predict_angles(r, g, b));
        if (burst_left > 0) burst_left--;
    endtask

    task automatic push_random(int count);
        t_rgb px;
        repeat (count) begin
            px = random_rgb();
            push_pixel(px.red, px.green, px.blue);
        end
    endtask

    task automatic compare_field(string field, t_pixel_angles px, longint want_v, longint got_v);
        if (want_v != got_v) begin
            mismatches++;
            $display("%0t: %s of rgb (%0d,%0d,%0d): expected %0d, got %0d", $time, field,
                     px.red, px.green, px.blue, want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (angles_due.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result: expected none, got tdata %h", $time,
                         o_m_axis_tdata);
            end else begin
                want = angles_due.pop_front();
                compare_field("c1", want, longint'(want.c1), longint'(o_m_axis_tdata[0 +: C_W]));
                compare_field("c2", want, longint'(want.c2),
                              longint'(o_m_axis_tdata[C_W +: C_W]));
                compare_field("c3", want, longint'(want.c3),
                              longint'(o_m_axis_tdata[2 * C_W +: C_W]));
                compare_field("hue", want, longint'(want.hue),
                              longint'($signed(o_m_axis_tdata[3 * C_W +: ANG_W])));
                compare_field("pad", want, 0,
                              longint'(o_m_axis_tdata[OUT_TDATA_W-1:PAD_LSB]));
            end
        end

        // output side stall pattern
        if (hold_seen != hold_seq) begin
            hold_left = hold_len;
            hold_seen = hold_seq;
        end
        tick++;
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rdy_mode  = t_ready_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(8, 150);
            end else begin
                mode_left--;
            end
            case (rdy_mode)
                RDY_ALWAYS:    i_m_axis_tready <= 1'b1;
                RDY_COIN:      i_m_axis_tready <= 1'($urandom_range(0, 1));
                RDY_EVERY_4TH: i_m_axis_tready <= (tick[1:0] == 2'd0);
                default:       i_m_axis_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    task automatic test_directed_corners();
        push_pixel(8'd0,   8'd0,   8'd0);     // black: every angle from atan2(0,0)
        push_pixel(8'd255, 8'd255, 8'd255);
        push_pixel(8'd255, 8'd0,   8'd0);     // c1 at the quarter-turn clamp
        push_pixel(8'd0,   8'd255, 8'd0);
        push_pixel(8'd0,   8'd0,   8'd255);
        push_pixel(8'd255, 8'd255, 8'd0);
        push_pixel(8'd255, 8'd0,   8'd255);
        push_pixel(8'd0,   8'd255, 8'd255);   // hue straight angle, zero y
        push_pixel(8'd1,   8'd0,   8'd0);
        push_pixel(8'd0,   8'd1,   8'd0);
        push_pixel(8'd0,   8'd0,   8'd1);
        push_pixel(8'd0,   8'd128, 8'd128);
        push_pixel(8'd200, 8'd100, 8'd100);   // hue zero
        push_pixel(8'd0,   8'd1,   8'd2);     // hue just above minus pi
        push_pixel(8'd0,   8'd2,   8'd1);     // hue just below pi
        push_pixel(8'd100, 8'd150, 8'd50);    // x zero, y positive
        push_pixel(8'd100, 8'd50,  8'd150);   // x zero, y negative
        push_pixel(8'd128, 8'd128, 8'd128);
        push_pixel(8'd1,   8'd255, 8'd254);
        push_pixel(8'd254, 8'd1,   8'd0);
        push_pixel(8'd170, 8'd85,  8'd85);
    endtask

    task automatic test_random_pixels(int count);
        gaps_on = 1'b1;
        push_random(count);
    endtask

    // long output stall with the input kept busy, so the pipeline fills and backs up
    task automatic test_output_hold_off();
        gaps_on  = 1'b0;
        hold_len = 400;
        hold_seq++;
        push_random(200);
        gaps_on = 1'b1;
    endtask

    task automatic test_pause_until_drained();
        push_random(50);
        i_s_axis_tvalid <= 1'b0;
        while (angles_due.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
        push_random(50);
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        // first micro-rotation is pi/4 from machin's formula
        atan_steps[0] = 4 * atan_recip(5) - atan_recip(239);
        for (int i = 1; i < ROT_STEPS; i++) atan_steps[i] = atan_shifted(i);
        pi_half = 2 * atan_steps[0];
        pi_full = 4 * atan_steps[0];
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_corners();
        test_random_pixels(1000);
        test_output_hold_off();
        test_pause_until_drained();

        i_s_axis_tvalid <= 1'b0;
        while (angles_due.size() != 0) @(posedge i_clk);
        repeat (2 * PIPE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS rgb_to_c1c2c3_and_hue_unit");
        end else begin
            $display("FAIL rgb_to_c1c2c3_and_hue_unit");
        end
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("%0t: timeout with %0d results outstanding", $time, angles_due.size());
        $display("FAIL rgb_to_c1c2c3_and_hue_unit");
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/rgbch_pkg.sv
design/rgbch_atan2.sv
design/rgb_to_c1c2c3_and_hue_unit.sv
bench/tb_rgb_to_c1c2c3_and_hue_unit.sv
